/* rtl/core/mbt_pkg.sv */
`default_nettype none

package mbt_pkg;

    localparam int COORD_W = 6;
    localparam int CELL_W  = 5;
    localparam int MAC_W   = 12;

    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] ACT_CARVE   = 3'd0;
    localparam logic [2:0] ACT_BACK    = 3'd1;
    localparam logic [2:0] ACT_FINISH  = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_RESTART = 3'd4;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int VISITED_BIT = 4;
    localparam logic [CELL_W-1:0] VISITED_MASK = 5'b10000;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pick;
        logic [4:0] read_x;
        logic [4:0] read_y;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic [4:0] cur_x;
        logic [4:0] cur_y;
        logic [1:0] direction;
        logic [4:0] cell_bits;
    } rsp_t;

    typedef struct packed {
        coord_t w;
        coord_t h;
    } dims_t;

    // multiply-add request: a * b + c
    typedef struct packed {
        coord_t a;
        coord_t b;
        coord_t c;
    } mac_op_t;

    function automatic logic [CELL_W-1:0] path_bit(input logic [1:0] d);
        return CELL_W'(1) << d;
    endfunction

    function automatic logic [CELL_W-1:0] back_bit(input logic [1:0] d);
        logic [1:0] o;
        o = d + 2'd2;
        return CELL_W'(1) << o;
    endfunction

    // 4 = 1 mod 3, so the base-4 digit sum keeps the residue
    function automatic logic [1:0] mod3(input logic [7:0] p);
        logic [3:0] s;
        logic [1:0] r;
        s = 4'(p[1:0]) + 4'(p[3:2]) + 4'(p[5:4]) + 4'(p[7:6]);
        case (s) inside
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
            default:                       r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/maze_backtracker_step_top.sv */
// Every step, read or restart word yields one result (carve, backtrack, read, finish or restart);
// one word at a time, the next taken once the result is registered.
// Pace is set by the single-port cell store and the shared multiply-add forming cell addresses.
// Restart clears the cell store, one entry per cycle, then marks the origin cell visited.
// After reset the whole cell store is swept before the first word is taken;
// configuration writes are taken throughout.
`default_nettype none

module maze_backtracker_step_top #(
    parameter int MAX_SIDE  = 32,
    parameter int MAX_CELLS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  mbt_pkg::cmd_t               cmd,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output mbt_pkg::rsp_t               rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [mbt_pkg::COORD_W-1:0] cfg_data
);
    import mbt_pkg::*;

    localparam int AW    = $clog2(MAX_CELLS);
    localparam int DW    = $clog2(MAX_CELLS + 1);
    localparam int CMP_W = (DW > MAC_W) ? DW : MAC_W;
    localparam int SLOTS = 5;
    localparam int SW    = 2 * COORD_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_AREA   = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_SEL    = 4'd5;
    localparam logic [3:0] S_WR_TOP = 4'd6;
    localparam logic [3:0] S_WR_NEW = 4'd7;
    localparam logic [3:0] S_POP    = 4'd8;
    localparam logic [3:0] S_POP_LD = 4'd9;
    localparam logic [3:0] S_E_MAC  = 4'd10;
    localparam logic [3:0] S_E_RD   = 4'd11;
    localparam logic [3:0] S_E_DATA = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    // returns {y, x} one cell over in direction d
    function automatic logic [SW-1:0] step_to(input coord_t x, input coord_t y,
                                              input logic [1:0] d);
        coord_t nx;
        coord_t ny;
        nx = x;
        ny = y;
        unique case (d)
            DIR_N: ny = y - COORD_W'(1);
            DIR_E: nx = x + COORD_W'(1);
            DIR_S: ny = y + COORD_W'(1);
            DIR_W: nx = x - COORD_W'(1);
        endcase
        return {ny, nx};
    endfunction

    logic [3:0]      state_reg, state_next;
    coord_t          cfg_w_reg, cfg_w_next;
    coord_t          cfg_h_reg, cfg_h_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [DW-1:0]   visited_reg, visited_next;
    logic            finished_reg, finished_next;
    logic [2:0]      scan_cnt_reg, scan_cnt_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            clr_restart_reg, clr_restart_next;
    logic            rsp_valid_reg, rsp_valid_next;

    logic [7:0]      pick_reg, pick_next;
    coord_t          top_x_reg, top_x_next;
    coord_t          top_y_reg, top_y_next;
    logic [AW-1:0]   slot_idx_reg [SLOTS];
    logic [AW-1:0]   slot_idx_next [SLOTS];
    logic [CELL_W-1:0] slot_bits_reg [SLOTS];
    logic [CELL_W-1:0] slot_bits_next [SLOTS];
    logic [1:0]      dir_reg, dir_next;
    coord_t          em_x_reg, em_x_next;
    coord_t          em_y_reg, em_y_next;
    logic            em_valid_reg, em_valid_next;
    logic [2:0]      em_act_reg, em_act_next;
    rsp_t            res_reg, res_next;
    rsp_t            rsp_reg, rsp_next;

    logic [CELL_W-1:0] cell_mem [MAX_CELLS];
    logic [CELL_W-1:0] cell_rdata_reg;
    logic [AW-1:0]     cm_addr;
    logic              cm_we;
    logic              cm_re;
    logic [CELL_W-1:0] cm_wdata;

    logic [SW-1:0]   stack_mem [MAX_CELLS];
    logic [SW-1:0]   stack_rdata_reg;
    logic [AW-1:0]   sk_addr;
    logic            sk_we;
    logic            sk_re;
    logic [SW-1:0]   sk_wdata;

    dims_t           dims;
    mac_op_t         mac_op;
    logic [MAC_W-1:0] mac_q;

    logic            top_in_grid;
    logic            em_in_grid;
    logic [3:0]      nb_ok;
    logic [4:0]      slot_ok;
    logic [SW-1:0]   slot_xy;
    logic [2:0]      scan_s1;
    logic [2:0]      scan_s2;
    logic [3:0]      cand;
    logic [2:0]      cand_n;
    logic [1:0]      pick_j;
    logic [1:0]      seen;
    logic [1:0]      sel_dir;
    logic [SW-1:0]   new_xy;
    logic [CELL_W-1:0] new_bits;
    logic            area_done;

    mbt_dims #(
        .MAX_SIDE  (MAX_SIDE),
        .MAX_CELLS (MAX_CELLS)
    ) u_dims (
        .maze_width  (cfg_w_reg),
        .maze_height (cfg_h_reg),
        .dims        (dims)
    );

    mbt_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .q   (mac_q)
    );

    assign cfg_ready = 1'b1;
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        top_in_grid = (top_x_reg < dims.w) && (top_y_reg < dims.h);
        em_in_grid  = (em_x_reg < dims.w) && (em_y_reg < dims.h);
        nb_ok[0] = (top_y_reg != '0);
        nb_ok[1] = ({1'b0, top_x_reg} + (COORD_W+1)'(1)) < {1'b0, dims.w};
        nb_ok[2] = ({1'b0, top_y_reg} + (COORD_W+1)'(1)) < {1'b0, dims.h};
        nb_ok[3] = (top_x_reg != '0);
        slot_ok  = {1'b1, nb_ok};
        if (scan_cnt_reg < 3'd4)
            slot_xy = step_to(top_x_reg, top_y_reg, scan_cnt_reg[1:0]);
        else
            slot_xy = {top_y_reg, top_x_reg};
        scan_s1 = scan_cnt_reg - 3'd1;
        scan_s2 = scan_cnt_reg - 3'd2;
        for (int k = 0; k < 4; k++)
            cand[k] = nb_ok[k] && !slot_bits_reg[k][VISITED_BIT];
        cand_n = 3'($countones(cand));
        case (cand_n)
            3'd2:    pick_j = {1'b0, pick_reg[0]};
            3'd3:    pick_j = mod3(pick_reg);
            3'd4:    pick_j = pick_reg[1:0];
            default: pick_j = 2'd0;
        endcase
        seen    = 2'd0;
        sel_dir = DIR_N;
        for (int k = 0; k < 4; k++)
        begin
            if (cand[k])
            begin
                if (seen == pick_j)
                    sel_dir = 2'(k);
                seen = seen + 2'd1;
            end
        end
        new_xy    = step_to(top_x_reg, top_y_reg, dir_reg);
        new_bits  = slot_bits_reg[{1'b0, dir_reg}] | back_bit(dir_reg) | VISITED_MASK;
        area_done = CMP_W'(visited_reg) >= CMP_W'(mac_q);
    end

    always_comb
    begin
        state_next       = state_reg;
        cfg_w_next       = cfg_w_reg;
        cfg_h_next       = cfg_h_reg;
        depth_next       = depth_reg;
        visited_next     = visited_reg;
        finished_next    = finished_reg;
        scan_cnt_next    = scan_cnt_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_restart_next = clr_restart_reg;
        rsp_valid_next   = rsp_valid_reg;
        pick_next        = pick_reg;
        top_x_next       = top_x_reg;
        top_y_next       = top_y_reg;
        slot_idx_next    = slot_idx_reg;
        slot_bits_next   = slot_bits_reg;
        dir_next         = dir_reg;
        em_x_next        = em_x_reg;
        em_y_next        = em_y_reg;
        em_valid_next    = em_valid_reg;
        em_act_next      = em_act_reg;
        res_next         = res_reg;
        rsp_next         = rsp_reg;

        mac_op   = '0;
        cm_addr  = '0;
        cm_we    = 1'b0;
        cm_re    = 1'b0;
        cm_wdata = '0;
        sk_addr  = '0;
        sk_we    = 1'b0;
        sk_re    = 1'b0;
        sk_wdata = '0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  cfg_w_next = cfg_data;
                CFG_HEIGHT: cfg_h_next = cfg_data;
            endcase
        end

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pick_next = cmd.pick;
                    unique case (cmd.opcode)
                        OP_RESTART:
                        begin
                            clr_cnt_next     = AW'(MAX_CELLS - 1);
                            clr_restart_next = 1'b1;
                            state_next       = S_CLR;
                        end
                        OP_STEP:
                            state_next = S_AREA;
                        OP_READ:
                        begin
                            em_x_next     = COORD_W'(cmd.read_x);
                            em_y_next     = COORD_W'(cmd.read_y);
                            em_valid_next = 1'b1;
                            em_act_next   = ACT_READ;
                            state_next    = S_E_MAC;
                        end
                        OP_NONE:
                            state_next = S_IDLE;
                    endcase
                end
            end

            S_CLR:
            begin
                cm_we   = 1'b1;
                cm_addr = clr_cnt_reg;
                if (clr_cnt_reg == '0 && clr_restart_reg)
                    cm_wdata = VISITED_MASK;
                if (clr_cnt_reg == '0)
                begin
                    if (clr_restart_reg)
                    begin
                        sk_we         = 1'b1;
                        depth_next    = DW'(1);
                        visited_next  = DW'(1);
                        finished_next = 1'b0;
                        top_x_next    = '0;
                        top_y_next    = '0;
                        res_next      = '{ACT_RESTART, 5'd0, 5'd0, DIR_N, VISITED_MASK};
                        state_next    = S_DONE;
                    end
                    else
                        state_next = S_IDLE;
                end
                else
                    clr_cnt_next = clr_cnt_reg - AW'(1);
            end

            S_AREA:
            begin
                mac_op     = '{dims.h, dims.w, '0};
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (finished_reg || depth_reg == '0 || area_done)
                begin
                    finished_next = 1'b1;
                    em_x_next     = top_x_reg;
                    em_y_next     = top_y_reg;
                    em_valid_next = (depth_reg != '0);
                    em_act_next   = ACT_FINISH;
                    state_next    = S_E_MAC;
                end
                else if (!top_in_grid)
                    state_next = S_POP;
                else
                begin
                    scan_cnt_next = 3'd0;
                    state_next    = S_SCAN;
                end
            end

            // address, read and capture of five cells overlap, one slot per cycle
            S_SCAN:
            begin
                mac_op = '{slot_xy[SW-1:COORD_W], dims.w, slot_xy[COORD_W-1:0]};
                if (scan_cnt_reg >= 3'd1 && scan_cnt_reg <= 3'd5)
                begin
                    slot_idx_next[scan_s1] = AW'(mac_q);
                    cm_addr = AW'(mac_q);
                    cm_re   = slot_ok[scan_s1];
                end
                if (scan_cnt_reg >= 3'd2)
                    slot_bits_next[scan_s2] = slot_ok[scan_s2] ? cell_rdata_reg : '0;
                if (scan_cnt_reg == 3'd6)
                    state_next = S_SEL;
                else
                    scan_cnt_next = scan_cnt_reg + 3'd1;
            end

            S_SEL:
            begin
                if (cand_n == 3'd0)
                    state_next = S_POP;
                else if (depth_reg >= DW'(MAX_CELLS))
                begin
                    finished_next = 1'b1;
                    em_x_next     = top_x_reg;
                    em_y_next     = top_y_reg;
                    em_valid_next = 1'b1;
                    em_act_next   = ACT_FINISH;
                    state_next    = S_E_MAC;
                end
                else
                begin
                    dir_next   = sel_dir;
                    state_next = S_WR_TOP;
                end
            end

            S_WR_TOP:
            begin
                cm_we      = 1'b1;
                cm_addr    = slot_idx_reg[SLOTS-1];
                cm_wdata   = slot_bits_reg[SLOTS-1] | path_bit(dir_reg);
                sk_we      = 1'b1;
                sk_addr    = AW'(depth_reg);
                sk_wdata   = new_xy;
                state_next = S_WR_NEW;
            end

            S_WR_NEW:
            begin
                cm_we        = 1'b1;
                cm_addr      = slot_idx_reg[{1'b0, dir_reg}];
                cm_wdata     = new_bits;
                depth_next   = depth_reg + DW'(1);
                visited_next = visited_reg + DW'(1);
                top_x_next   = new_xy[COORD_W-1:0];
                top_y_next   = new_xy[SW-1:COORD_W];
                res_next     = '{ACT_CARVE, new_xy[4:0], new_xy[COORD_W+4:COORD_W],
                                 dir_reg, new_bits};
                state_next   = S_DONE;
            end

            S_POP:
            begin
                depth_next = depth_reg - DW'(1);
                if (depth_reg >= DW'(2))
                begin
                    sk_re      = 1'b1;
                    sk_addr    = AW'(depth_reg - DW'(2));
                    state_next = S_POP_LD;
                end
                else
                begin
                    em_valid_next = 1'b0;
                    em_act_next   = ACT_BACK;
                    state_next    = S_E_MAC;
                end
            end

            S_POP_LD:
            begin
                top_x_next    = stack_rdata_reg[COORD_W-1:0];
                top_y_next    = stack_rdata_reg[SW-1:COORD_W];
                em_x_next     = stack_rdata_reg[COORD_W-1:0];
                em_y_next     = stack_rdata_reg[SW-1:COORD_W];
                em_valid_next = 1'b1;
                em_act_next   = ACT_BACK;
                state_next    = S_E_MAC;
            end

            S_E_MAC:
            begin
                mac_op = '{em_y_reg, dims.w, em_x_reg};
                if (!em_valid_reg)
                begin
                    res_next   = '{em_act_reg, 5'd0, 5'd0, DIR_N, 5'd0};
                    state_next = S_DONE;
                end
                else if (!em_in_grid)
                begin
                    res_next   = '{em_act_reg, em_x_reg[4:0], em_y_reg[4:0], DIR_N, 5'd0};
                    state_next = S_DONE;
                end
                else
                    state_next = S_E_RD;
            end

            S_E_RD:
            begin
                cm_re      = 1'b1;
                cm_addr    = AW'(mac_q);
                state_next = S_E_DATA;
            end

            S_E_DATA:
            begin
                res_next   = '{em_act_reg, em_x_reg[4:0], em_y_reg[4:0], DIR_N, cell_rdata_reg};
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            cfg_w_reg       <= COORD_W'(32);
            cfg_h_reg       <= COORD_W'(32);
            depth_reg       <= '0;
            visited_reg     <= '0;
            finished_reg    <= 1'b0;
            scan_cnt_reg    <= '0;
            clr_cnt_reg     <= AW'(MAX_CELLS - 1);
            clr_restart_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cfg_w_reg       <= cfg_w_next;
            cfg_h_reg       <= cfg_h_next;
            depth_reg       <= depth_next;
            visited_reg     <= visited_next;
            finished_reg    <= finished_next;
            scan_cnt_reg    <= scan_cnt_next;
            clr_cnt_reg     <= clr_cnt_next;
            clr_restart_reg <= clr_restart_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg      <= pick_next;
        top_x_reg     <= top_x_next;
        top_y_reg     <= top_y_next;
        slot_idx_reg  <= slot_idx_next;
        slot_bits_reg <= slot_bits_next;
        dir_reg       <= dir_next;
        em_x_reg      <= em_x_next;
        em_y_reg      <= em_y_next;
        em_valid_reg  <= em_valid_next;
        em_act_reg    <= em_act_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
            cell_mem[cm_addr] <= cm_wdata;
        if (cm_re)
            cell_rdata_reg <= cell_mem[cm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sk_we)
            stack_mem[sk_addr] <= sk_wdata;
        if (sk_re)
            stack_rdata_reg <= stack_mem[sk_addr];
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MAX_CELLS))
        else $error("stack depth beyond capacity");

    a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR_NEW |=> depth_reg == $past(depth_reg) + DW'(1))
        else $error("carve did not push");

    a_cell_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cm_we && cm_re))
        else $error("cell store read and written together");

    a_carve_visited: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.action == ACT_CARVE |-> rsp.cell_bits[VISITED_BIT])
        else $error("carved cell not visited");

endmodule

`default_nettype wire

/* rtl/core/mbt_dims.sv */
`default_nettype none

module mbt_dims #(
    parameter int MAX_SIDE  = 32,
    parameter int MAX_CELLS = 1024
) (
    input  logic [mbt_pkg::COORD_W-1:0] maze_width,
    input  logic [mbt_pkg::COORD_W-1:0] maze_height,
    output mbt_pkg::dims_t              dims
);
    import mbt_pkg::*;

    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int SIDE_CAP  = (MAX_SIDE > COORD_MAX) ? COORD_MAX : MAX_SIDE;

    logic [COORD_W-1:0] lim_tab [COORD_MAX+1];
    coord_t w_clamp;
    coord_t h_clamp;
    coord_t lim;

    assign lim_tab[0] = '0;

    // rows allowed for each width
    for (genvar i = 1; i <= COORD_MAX; i++)
    begin : g_lim
        localparam int LIM = MAX_CELLS / i;
        assign lim_tab[i] = COORD_W'((LIM > COORD_MAX) ? COORD_MAX : LIM);
    end

    always_comb
    begin
        w_clamp = maze_width;
        if (w_clamp == '0)
            w_clamp = COORD_W'(1);
        if (w_clamp > COORD_W'(SIDE_CAP))
            w_clamp = COORD_W'(SIDE_CAP);
        lim = lim_tab[w_clamp];
        h_clamp = maze_height;
        if (h_clamp == '0)
            h_clamp = COORD_W'(1);
        if (h_clamp > COORD_W'(SIDE_CAP))
            h_clamp = COORD_W'(SIDE_CAP);
        if (h_clamp > lim)
            h_clamp = lim;
        dims.w = w_clamp;
        dims.h = h_clamp;
    end

endmodule

`default_nettype wire

/* rtl/core/mbt_mac.sv */
`default_nettype none

module mbt_mac (
    input  logic                       clk,
    input  mbt_pkg::mac_op_t           op,
    output logic [mbt_pkg::MAC_W-1:0]  q
);
    import mbt_pkg::*;

    logic [MAC_W-1:0] q_reg;
    logic [MAC_W-1:0] q_next;

    always_comb
    begin
        q_next = MAC_W'(op.a) * MAC_W'(op.b) + MAC_W'(op.c);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* sim/maze_checker.sv */
`default_nettype none

module maze_checker #(
    parameter int MAX_SIDE  = 32,
    parameter int MAX_CELLS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic                        cmd_stall,
    input  mbt_pkg::cmd_t               cmd,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  mbt_pkg::rsp_t               rsp,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [mbt_pkg::COORD_W-1:0] cfg_data,
    output int                          fail_count,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mbt_pkg::*;

    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;
    logic [4:0]         cells [MAX_CELLS];
    logic [4:0]         trail_x [MAX_CELLS];
    logic [4:0]         trail_y [MAX_CELLS];
    int unsigned        depth;
    int unsigned        visited;
    bit                 done_flag;
    rsp_t               awaited [$];

    function automatic int unsigned cols();
        int unsigned v;
        v = width_reg;
        if (v == 0) v = 1;
        if (v > MAX_SIDE) v = MAX_SIDE;
        return v;
    endfunction

    function automatic int unsigned rows();
        int unsigned v;
        int unsigned lim;
        v = height_reg;
        lim = MAX_CELLS / cols();
        if (v == 0) v = 1;
        if (v > MAX_SIDE) v = MAX_SIDE;
        if (v > lim) v = lim;
        return v;
    endfunction

    function automatic bit on_grid(input int unsigned x, input int unsigned y);
        return x < cols() && y < rows();
    endfunction

    function automatic logic [4:0] cell_at(input int unsigned x, input int unsigned y);
        if (!on_grid(x, y))
            return 5'd0;
        return cells[(y * cols() + x) % MAX_CELLS];
    endfunction

    function automatic bit fresh_cell(input int unsigned x, input int unsigned y);
        return (cell_at(x, y) & VISITED_MASK) == 5'd0;
    endfunction

    function automatic rsp_t make_rsp(input logic [2:0] act, input int unsigned x,
                                      input int unsigned y, input logic [1:0] dir,
                                      input logic [4:0] bits);
        rsp_t r;
        r.action    = act;
        r.cur_x     = 5'(x);
        r.cur_y     = 5'(y);
        r.direction = dir;
        r.cell_bits = bits;
        return r;
    endfunction

    function automatic rsp_t top_rsp(input logic [2:0] act, input logic [1:0] dir);
        int unsigned x;
        int unsigned y;
        if (depth == 0)
            return make_rsp(act, 0, 0, DIR_N, 5'd0);
        x = trail_x[depth - 1];
        y = trail_y[depth - 1];
        return make_rsp(act, x, y, dir, cell_at(x, y));
    endfunction

    task automatic predict_move(input cmd_t c, output rsp_t r, output bit has);
        int unsigned x;
        int unsigned y;
        int unsigned nx;
        int unsigned ny;
        int unsigned n;
        int unsigned w;
        int unsigned h;
        logic [1:0]  cand [4];
        logic [1:0]  d;
        logic [1:0]  opp;
        has = 1'b1;
        r = '0;
        case (c.opcode)
            OP_RESTART:
            begin
                for (int i = 0; i < MAX_CELLS; i++)
                    cells[i] = 5'd0;
                cells[0] = VISITED_MASK;
                trail_x[0] = 5'd0;
                trail_y[0] = 5'd0;
                depth = 1;
                visited = 1;
                done_flag = 1'b0;
                r = make_rsp(ACT_RESTART, 0, 0, DIR_N, VISITED_MASK);
            end
            OP_READ:
                r = make_rsp(ACT_READ, c.read_x, c.read_y, DIR_N, cell_at(c.read_x, c.read_y));
            OP_NONE:
                has = 1'b0;
            default:
            begin
                w = cols();
                h = rows();
                if (done_flag || depth == 0 || visited >= w * h)
                begin
                    done_flag = 1'b1;
                    r = top_rsp(ACT_FINISH, DIR_N);
                end
                else
                begin
                    x = trail_x[depth - 1];
                    y = trail_y[depth - 1];
                    n = 0;
                    if (on_grid(x, y))
                    begin
                        if (y > 0 && fresh_cell(x, y - 1)) begin cand[n] = DIR_N; n++; end
                        if (x + 1 < w && fresh_cell(x + 1, y)) begin cand[n] = DIR_E; n++; end
                        if (y + 1 < h && fresh_cell(x, y + 1)) begin cand[n] = DIR_S; n++; end
                        if (x > 0 && fresh_cell(x - 1, y)) begin cand[n] = DIR_W; n++; end
                    end
                    if (n == 0)
                    begin
                        depth--;
                        r = top_rsp(ACT_BACK, DIR_N);
                    end
                    else if (depth >= MAX_CELLS)
                    begin
                        done_flag = 1'b1;
                        r = top_rsp(ACT_FINISH, DIR_N);
                    end
                    else
                    begin
                        d = cand[c.pick % n];
                        opp = d + 2'd2;
                        nx = x;
                        ny = y;
                        case (d)
                            DIR_N:   ny = y - 1;
                            DIR_E:   nx = x + 1;
                            DIR_S:   ny = y + 1;
                            default: nx = x - 1;
                        endcase
                        cells[(y * w + x) % MAX_CELLS] =
                            cells[(y * w + x) % MAX_CELLS] | (5'd1 << d);
                        cells[(ny * w + nx) % MAX_CELLS] =
                            cells[(ny * w + nx) % MAX_CELLS] | (5'd1 << opp) | VISITED_MASK;
                        trail_x[depth] = 5'(nx);
                        trail_y[depth] = 5'(ny);
                        depth++;
                        visited++;
                        r = top_rsp(ACT_CARVE, d);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        rsp_t next;
        bit   has;
        if (!rst_n)
        begin
            width_reg = 6'd32;
            height_reg = 6'd32;
            for (int i = 0; i < MAX_CELLS; i++)
                cells[i] = 5'd0;
            depth = 0;
            visited = 0;
            done_flag = 1'b0;
            awaited.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected word: act=%0d x=%0d y=%0d dir=%0d bits=%02h",
                                 rsp.action, rsp.cur_x, rsp.cur_y, rsp.direction,
                                 rsp.cell_bits);
                    fail_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (want.action !== rsp.action || want.cur_x !== rsp.cur_x ||
                        want.cur_y !== rsp.cur_y || want.direction !== rsp.direction ||
                        want.cell_bits !== rsp.cell_bits)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: want act=%0d x=%0d y=%0d dir=%0d bits=%02h,",
                                      " got act=%0d x=%0d y=%0d dir=%0d bits=%02h"},
                                     want.action, want.cur_x, want.cur_y, want.direction,
                                     want.cell_bits, rsp.action, rsp.cur_x, rsp.cur_y,
                                     rsp.direction, rsp.cell_bits);
                        fail_count++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                predict_move(cmd, next, has);
                if (has)
                    awaited = {awaited, next};
            end
            outstanding = awaited.size();
        end
    end

endmodule

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbt_pkg::*;

    localparam int LIMIT     = 2_000_000;
    localparam int HOLD_LEN  = 1500;
    localparam int TARGET    = 1225;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    cmd_t               cmd       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_t               rsp;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [COORD_W-1:0] cfg_data  = '0;

    int fail_count;
    int outstanding;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int sent          = 0;

    maze_backtracker_step_top #(
        .MAX_SIDE  (32),
        .MAX_CELLS (1024)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    maze_checker #(
        .MAX_SIDE  (32),
        .MAX_CELLS (1024)
    ) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // long hold-offs keep the output register full so the input backs up
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    function automatic cmd_t word(input logic [1:0] op, input int p, input int x, input int y);
        cmd_t c;
        c.opcode = op;
        c.pick   = 8'(p);
        c.read_x = 5'(x);
        c.read_y = 5'(y);
        return c;
    endfunction

    function automatic cmd_t rand_word(input logic [1:0] op);
        return word(op, $urandom_range(255), $urandom_range(31), $urandom_range(31));
    endfunction

    function automatic int extreme_dim();
        case ($urandom_range(4))
            0:       return 0;
            1:       return 1;
            2:       return 32;
            3:       return 63;
            default: return $urandom_range(62, 33);
        endcase
    endfunction

    function automatic int clamp_dim(input int v);
        if (v == 0)
            return 1;
        if (v > 32)
            return 32;
        return v;
    endfunction

    task automatic send(input cmd_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (w.opcode != OP_NONE)
            sent++;
    endtask

    // the first wait lets the checker count a word taken at the last edge
    task automatic quiesce();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= COORD_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dims(input int w, input int h);
        quiesce();
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
    endtask

    task automatic run_maze(input bit fresh, input bit squeeze, input int steps);
        int r;
        if (fresh)
            send(rand_word(OP_RESTART));
        if (squeeze)
            hold_req++;
        repeat (steps)
        begin
            r = $urandom_range(99);
            if (r < 6)
                send(rand_word(OP_READ));
            else if (r < 9)
                send(rand_word(OP_NONE));
            else if (r < 10)
                send(rand_word(OP_RESTART));
            else
                send(rand_word(OP_STEP));
        end
    endtask

    initial
    begin : stim
        int  dw;
        int  dh;
        int  steps;
        int  r;
        int  regime;
        int  last_regime;
        bit  first;
        last_regime = -1;
        first = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack, reads, unused opcode, then a short carve at full size
        send(word(OP_STEP, 0, 0, 0));
        send(word(OP_READ, 0, 0, 0));
        send(word(OP_READ, 255, 31, 31));
        send(word(OP_NONE, 170, 21, 10));
        send(word(OP_RESTART, 85, 10, 21));
        send(word(OP_STEP, 255, 0, 0));
        send(word(OP_STEP, 0, 31, 31));
        send(word(OP_STEP, 128, 0, 0));
        send(word(OP_READ, 0, 31, 0));

        // zero dimensions count as one: single cell finishes at once
        set_dims(0, 0);
        send(word(OP_RESTART, 0, 0, 0));
        send(word(OP_STEP, 3, 0, 0));
        send(word(OP_STEP, 7, 0, 0));
        send(word(OP_READ, 0, 0, 0));
        send(word(OP_READ, 0, 1, 0));

        // narrow the grid under a stack top that has moved east
        set_dims(8, 8);
        send(word(OP_RESTART, 0, 0, 0));
        repeat (3) send(word(OP_STEP, 0, 0, 0));
        set_dims(2, 8);
        repeat (3) send(word(OP_STEP, 1, 0, 0));
        send(word(OP_READ, 0, 3, 0));

        set_dims(63, 40);
        send(word(OP_RESTART, 0, 0, 0));
        send(word(OP_STEP, 2, 0, 0));

        while (sent < TARGET)
        begin
            regime = sent * 3 / TARGET;
            case (regime)
                0:
                begin
                    send_idle_pct = 32;
                    stall_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    stall_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            if ($urandom_range(3) == 0)
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            r = $urandom_range(99);
            if (r < 70)
            begin
                dw = $urandom_range(8, 1);
                dh = $urandom_range(8, 1);
            end
            else if (r < 85)
            begin
                dw = extreme_dim();
                dh = $urandom_range(4, 0);
            end
            else
            begin
                dw = $urandom_range(4, 0);
                dh = extreme_dim();
            end
            set_dims(dw, dh);
            steps = 2 * clamp_dim(dw) * clamp_dim(dh) + $urandom_range(6, 2);
            if (steps > 120)
                steps = 120;
            run_maze(first || $urandom_range(4) != 0, regime != last_regime, steps);
            last_regime = regime;
            first = 1'b0;
        end

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
